FILE: sv/pjq_pkg.sv
package pjq_pkg;

    // queue size and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int PRIO_W      = 8;
    localparam int OCC_W       = 5;

    // operation codes carried on s_tuser
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // result status codes carried on m_tuser
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // one stored job
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic              fifo_ties;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } cmd_t;

endpackage

FILE: sv/priority_job_queue.sv
// Sorted job queue of pjq_pkg::QUEUE_DEPTH entries, head (smallest priority value) first.
// Each beat on s_ is an insert or a pop; every beat gives exactly one result beat on m_,
// registered in the cycle after acceptance. One beat is taken every cycle unless an untaken
// result stalls m_: a row of cells, one per entry, compares its stored priority with the
// broadcast priority of the new job and in the same cycle keeps its entry, takes the new
// job or takes its neighbor's entry, so an insert or pop is no slower with a fuller queue.
// cfg_wdata written with cfg_we selects tie order: 1 puts a new job behind equal priorities,
// 0 ahead of them. Write it only while the block is idle.
module priority_job_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // job_tag[15:0], priority_req[23:16]
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_tag[15:0], out_priority[23:16], occupancy[28:24]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int DEPTH = pjq_pkg::QUEUE_DEPTH;
    localparam int CW    = pjq_pkg::CNT_W;

    logic                  fifo_ties_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_tvalid_reg;
    pjq_pkg::status_t      status_reg;
    pjq_pkg::status_t      status_next;
    pjq_pkg::entry_t       out_entry_reg;
    pjq_pkg::entry_t       out_entry_next;
    logic [CW-1:0]         occ_reg;

    logic                  s_acc;
    logic                  is_pop;
    logic                  is_full;
    logic                  is_empty;
    pjq_pkg::cmd_t         cmd;
    logic [DEPTH-1:0]      occupied;
    logic [DEPTH-1:0]      after;
    pjq_pkg::entry_t       cells [DEPTH];
    pjq_pkg::entry_t       tie_off;

    // handshake: output register frees as the result is taken
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign is_pop   = (s_tuser[0] == pjq_pkg::FUNC_POP);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // command broadcast to the cells
    always_comb begin
        cmd.ins       = s_acc && !is_pop && !is_full;
        cmd.pop       = s_acc && is_pop && !is_empty;
        cmd.fifo_ties = fifo_ties_reg;
        cmd.tag       = s_tdata[15:0];
        cmd.prio      = s_tdata[23:16];
    end

    // thermometer of held entries
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occupied[i] = (CW'(i) < count_reg);
        end
    end

    assign tie_off = '0;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pjq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occupied    (occupied[g]),
            .left_after  ((g == 0) ? 1'b1 : after[(g == 0) ? 0 : g-1]),
            .left_entry  (cells[(g == 0) ? 0 : g-1]),
            .right_entry ((g == DEPTH-1) ? tie_off : cells[(g == DEPTH-1) ? g : g+1]),
            .after       (after[g]),
            .entry       (cells[g])
        );
    end

    // result and count
    always_comb begin
        count_next     = count_reg;
        status_next    = pjq_pkg::STAT_OK;
        out_entry_next = '0;
        if (is_pop) begin
            if (is_empty) begin
                status_next = pjq_pkg::STAT_EMPTY;
            end else begin
                out_entry_next = cells[0];
                count_next     = count_reg - 1'b1;
            end
        end else begin
            if (is_full) begin
                status_next = pjq_pkg::STAT_FULL;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fifo_ties_reg <= 1'b0;
            count_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                fifo_ties_reg <= cfg_wdata;
            end
            if (s_acc) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            status_reg    <= status_next;
            out_entry_reg <= out_entry_next;
            occ_reg       <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, pjq_pkg::OCC_W'(occ_reg), out_entry_reg.prio, out_entry_reg.tag};

`ifndef SYNTH
    // count stays within the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond queue depth");

    // head pair stays sorted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(2)) |-> (cells[0].prio <= cells[1].prio))
        else $error("head entries out of order");

    // a pop on a held job drops the count by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && is_pop && !is_empty) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement count");

    // an insert into a full queue reports full and keeps the count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !is_pop && is_full)
        |=> (m_tuser == pjq_pkg::STAT_FULL) && (count_reg == CW'(DEPTH)))
        else $error("full insert not rejected");
`endif

endmodule

FILE: sv/pjq_cell.sv
module pjq_cell (
    input  logic            aclk,
    input  pjq_pkg::cmd_t   cmd,
    input  logic            occupied,
    input  logic            left_after,
    input  pjq_pkg::entry_t left_entry,
    input  pjq_pkg::entry_t right_entry,
    output logic            after,
    output pjq_pkg::entry_t entry
);

    pjq_pkg::entry_t entry_reg;
    pjq_pkg::entry_t entry_next;

    // stored job stays ahead of the new one
    always_comb begin
        if (cmd.fifo_ties) begin
            after = occupied && (entry_reg.prio <= cmd.prio);
        end else begin
            after = occupied && (entry_reg.prio < cmd.prio);
        end
    end

    // keep, take the new job, or shift from a neighbor
    always_comb begin
        entry_next = entry_reg;
        if (cmd.pop) begin
            entry_next = right_entry;
        end else if (cmd.ins) begin
            if (after) begin
                entry_next = entry_reg;
            end else if (left_after) begin
                entry_next.tag  = cmd.tag;
                entry_next.prio = cmd.prio;
            end else begin
                entry_next = left_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
